FILE: rtl/obst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_pkg
// Shared types and codes of the ordered byte set table.
// ----------------------------------------------------------------------------
package obst_pkg;

    // Default number of table entries
    localparam int unsigned DEF_CAPACITY = 16;

    // Capacity limit register after reset
    localparam logic [4:0] CFG_LIMIT_RESET = 5'd16;

    // Request codes
    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_LOOKUP  = 3'd2;
    localparam logic [2:0] REQ_DISCARD = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_DUP    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_ABSENT = 3'd4;
    localparam logic [2:0] ST_BADPOS = 3'd5;

    // One result transaction
    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [7:0] element;
        logic [4:0] member_count;
    } t_rsp;

endpackage
`default_nettype wire

FILE: rtl/obst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_if
// Valid/ready channels of the ordered byte set table.
// ----------------------------------------------------------------------------

// Request channel
interface obst_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [15:0] value;
    logic [3:0]         position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

// Result channel
interface obst_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       found;
    logic [7:0] element;
    logic [4:0] member_count;

    modport source (output valid, output status, output found, output element,
                    output member_count, input ready);
    modport sink   (input valid, input status, input found, input element,
                    input member_count, output ready);
endinterface

// Capacity limit write channel
interface obst_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/obst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module obst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/obst_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_seq
// Request sequencer: scans the entry RAM, shifts the tail on removal,
// appends on insert and builds the result transaction.
// ----------------------------------------------------------------------------
module obst_seq #(
    parameter int unsigned CAPACITY = obst_pkg::DEF_CAPACITY,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    obst_req_if.sink           i_req,
    input  wire logic [4:0]    i_limit,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output obst_pkg::t_rsp     o_res,
    output logic               o_ram_we,
    output logic [IW-1:0]      o_ram_waddr,
    output logic [7:0]         o_ram_wdata,
    output logic [IW-1:0]      o_ram_raddr,
    input  wire logic [7:0]    i_ram_rdata
);
    import obst_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW > 4) ? CW : 4;
    localparam int unsigned LW = (CW > 5) ? CW : 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_type, n_type;
    logic [7:0]    r_value, n_value;
    logic          r_in_range, n_in_range;
    logic [3:0]    r_pos, n_pos;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_found, n_found;
    logic [CW-1:0] r_count, n_count;
    t_rsp          r_res, n_res;

    logic          accept;
    logic          shift_req;
    logic          hit;
    logic [CW:0]   next_idx;
    logic          more;
    logic [PW-1:0] pos_ext;
    logic          pos_ok;
    logic [LW-1:0] limit;
    logic          full;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign shift_req   = (r_type == REQ_REMOVE) || (r_type == REQ_DISCARD);

    // Scan compare and next read position
    assign hit      = !r_found && (i_ram_rdata == r_value);
    assign next_idx = (CW + 1)'(r_rd_idx) + (CW + 1)'(1);
    assign more     = next_idx < (CW + 1)'(r_count);

    // Position check and saturated capacity limit
    assign pos_ext = PW'(r_pos);
    assign pos_ok  = pos_ext < PW'(r_count);
    assign limit   = (LW'(i_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(i_limit);
    assign full    = LW'(r_count) >= limit;

    // Sequence one request
    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_value     = r_value;
        n_in_range  = r_in_range;
        n_pos       = r_pos;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_count     = r_count;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_rd_idx - IW'(1);
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = r_rd_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_type      = i_req.req_type;
                    n_value     = i_req.value[7:0];
                    n_in_range  = (i_req.value[15:8] == 8'd0);
                    n_pos       = i_req.position;
                    n_found     = 1'b0;
                    n_rd_idx    = '0;
                    o_ram_raddr = '0;
                    if ((i_req.value[15:8] == 8'd0) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_POS;
                    end
                end
            end
            S_SCAN: begin
                // Mark the match; on remove and discard, move later entries down one place
                if (hit) begin
                    n_found = 1'b1;
                end
                if (r_found && shift_req) begin
                    o_ram_we = 1'b1;
                end
                if (!more || (hit && !shift_req)) begin
                    n_state = S_POS;
                end else begin
                    n_rd_idx    = r_rd_idx + IW'(1);
                    o_ram_raddr = r_rd_idx + IW'(1);
                end
            end
            S_POS: begin
                o_ram_raddr = pos_ext[IW-1:0];
                n_state     = S_FIN;
            end
            S_FIN: begin
                n_res.status       = ST_OK;
                n_res.found        = r_found;
                n_res.element      = 8'd0;
                case (r_type)
                    REQ_INSERT: begin
                        if (!r_in_range) begin
                            n_res.status = ST_RANGE;
                        end else if (r_found) begin
                            n_res.status = ST_DUP;
                        end else if (full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_count[IW-1:0];
                            o_ram_wdata = r_value;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_found) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_res.status = ST_ABSENT;
                        end
                    end
                    REQ_DISCARD: begin
                        if (r_found) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    REQ_READ: begin
                        if (pos_ok) begin
                            n_res.element = i_ram_rdata;
                        end else begin
                            n_res.status = ST_BADPOS;
                        end
                    end
                    default: begin
                    end
                endcase
                n_res.member_count = 5'(n_count);
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
    end

    // Request payload and result
    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_value    <= n_value;
        r_in_range <= n_in_range;
        r_pos      <= n_pos;
        r_rd_idx   <= n_rd_idx;
        r_res      <= n_res;
    end

    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_count) <= (CW + 1)'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_ram_we) |-> (o_ram_waddr != o_ram_raddr))
        else $error("shift write hits the entry being read");

    a_shift_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_ram_we) |-> (r_found && shift_req))
        else $error("tail shift before a match");

    a_count_only_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> $stable(r_count))
        else $error("entry count changed outside finish");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_count == $past(r_count)
            || r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");
`endif

endmodule
`default_nettype wire

FILE: rtl/ordered_byte_set_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_byte_set_table_core
// Bounded set of distinct byte values kept in insertion order.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction. Requests are
// handled one at a time, through an optional scan, then the position, finish
// and output states. The entries sit in one RAM with a single read port, and
// the scan reads one entry per cycle; insert, lookup, read and unknown codes
// stop at the match, while remove and discard walk to the end so the tail
// moves down one place as it is read. Values outside 0..255 skip the scan. A
// finished result waits in an output register, so the next request is taken
// while the previous result is held. The capacity limit is written through the
// config channel; the user must do so only while idle, as the block does not
// enforce it. It saturates at CAPACITY. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module ordered_byte_set_table_core #(
    parameter int unsigned CAPACITY = obst_pkg::DEF_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    obst_req_if.sink  i_req,
    obst_rsp_if.source o_rsp,
    obst_cfg_if.sink  i_cfg
);
    import obst_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [4:0]    r_limit;
    logic          r_out_valid;
    t_rsp          r_out;

    logic          res_valid;
    logic          res_ready;
    t_rsp          res;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Capacity limit register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CFG_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    // Entry storage
    obst_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request sequencer
    obst_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_limit     (r_limit),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Output register: hold a result until the sink takes it
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.found        = r_out.found;
    assign o_rsp.element      = r_out.element;
    assign o_rsp.member_count = r_out.member_count;

endmodule
`default_nettype wire

FILE: test/ordered_byte_set_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_byte_set_table_core_test
// Self-checking bench for the ordered byte set table core. A mirror of the
// table predicts status, membership, read data and member count for every
// accepted request, and each result transaction is checked against the
// oldest prediction. A directed pass covers the range, duplicate, full,
// absent, bad position and unknown code cases, then random phases with a
// new capacity limit each stream well-formed traffic over a small value
// pool plus raw 16-bit values, idling both sides at random but in one phase.
// ----------------------------------------------------------------------------
module ordered_byte_set_table_core_test;
    import obst_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEF_CAPACITY;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_COUNT = 12;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned HOLD_AFTER  = 600;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_TAIL  = 40;

    // First of the three unassigned request codes
    localparam logic [2:0] REQ_SPARE = 3'd5;

    // Mirror of the table contents and the replies it predicts
    class byte_set_mirror;
        bit [7:0]    slots [TABLE_DEPTH];
        int unsigned fill;
        int unsigned limit;
        t_rsp        awaited_replies [$];
        int unsigned errors;

        function new();
            fill   = 0;
            limit  = CFG_LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [4:0] new_limit);
            limit = new_limit;
        endfunction

        // Close the gap at one position, keeping order
        function void drop_slot(int unsigned at);
            for (int unsigned i = at; i + 1 < fill; i++)
                slots[i] = slots[i + 1];
            fill--;
        endfunction

        // Predict the reply of one accepted request and update the mirror
        function void note_request(logic [2:0] kind, logic signed [15:0] value,
                                   logic [3:0] pos);
            t_rsp        reply;
            bit          in_range;
            int          at;
            int unsigned cap;
            in_range = (value[15:8] == 8'd0);
            at = -1;
            if (in_range) begin
                for (int unsigned i = 0; i < fill && at < 0; i++)
                    if (slots[i] == value[7:0])
                        at = i;
            end
            cap = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
            reply.status  = ST_OK;
            reply.found   = (at >= 0);
            reply.element = 8'd0;
            case (kind)
                REQ_INSERT: begin
                    if (!in_range)
                        reply.status = ST_RANGE;
                    else if (at >= 0)
                        reply.status = ST_DUP;
                    else if (fill >= cap)
                        reply.status = ST_FULL;
                    else begin
                        slots[fill] = value[7:0];
                        fill++;
                    end
                end
                REQ_REMOVE: begin
                    if (at >= 0)
                        drop_slot(at);
                    else
                        reply.status = ST_ABSENT;
                end
                REQ_DISCARD: begin
                    if (at >= 0)
                        drop_slot(at);
                end
                REQ_READ: begin
                    if (pos < fill)
                        reply.element = slots[pos];
                    else
                        reply.status = ST_BADPOS;
                end
                default: ;
            endcase
            reply.member_count = 5'(fill);
            awaited_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one result transaction against the oldest prediction
        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: result with nothing awaited, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("found", 8'(want.found), 8'(got.found));
            compare_field("element", want.element, got.element);
            compare_field("member_count", 8'(want.member_count), 8'(got.member_count));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    obst_req_if req_ch ();
    obst_rsp_if rsp_ch ();
    obst_cfg_if cfg_ch ();

    ordered_byte_set_table_core #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    byte_set_mirror table_model;
    bit             calm = 1'b0;
    int unsigned    replies_seen = 0;
    int unsigned    hold_left = 0;
    int unsigned    cycle_count = 0;
    bit [7:0]       value_pool [$];

    // Free-running clock
    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one request and wait for its transaction
    task automatic send_request(input logic [2:0] kind, input logic signed [15:0] value,
                                input logic [3:0] pos);
        if (!calm && $urandom_range(0, 99) < 36) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= value;
        req_ch.position <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        table_model.note_request(kind, value, pos);
    endtask

    // Build one random request, mostly over the phase's value pool
    task automatic send_random();
        int unsigned        roll;
        logic [2:0]         kind;
        logic signed [15:0] value;
        logic [3:0]         pos;
        roll = $urandom_range(0, 99);
        if (roll < 34)
            kind = REQ_INSERT;
        else if (roll < 48)
            kind = REQ_REMOVE;
        else if (roll < 60)
            kind = REQ_LOOKUP;
        else if (roll < 75)
            kind = REQ_DISCARD;
        else if (roll < 95)
            kind = REQ_READ;
        else
            kind = REQ_SPARE + 3'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 12)
            value = 16'($urandom());
        else
            value = {8'd0, value_pool[$urandom_range(0, value_pool.size() - 1)]};
        if ($urandom_range(0, 1) == 1 || table_model.fill == 0)
            pos = 4'($urandom_range(0, 15));
        else
            pos = 4'($urandom_range(0, table_model.fill - 1));
        send_request(kind, value, pos);
    endtask

    // Drop valid and wait until every predicted reply has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (table_model.awaited_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the capacity limit through the config channel
    task automatic write_limit(input logic [4:0] new_limit);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= new_limit;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        table_model.set_limit(new_limit);
    endtask

    // Accept result transactions, check them, and pace ready
    initial begin : reply_sink
        t_rsp got;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.status       = rsp_ch.status;
                got.found        = rsp_ch.found;
                got.element      = rsp_ch.element;
                got.member_count = rsp_ch.member_count;
                table_model.check_result(got);
                replies_seen++;
                // Hold off once so the core backs up and stalls its input
                if (replies_seen == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // Reset, directed pass, random phases, final verdict
    initial begin : stimulus
        logic [4:0]  phase_limits [PHASE_COUNT];
        int unsigned pool_size;
        table_model = new();
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.value    <= 16'sd0;
        req_ch.position <= 4'd0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= CFG_LIMIT_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: a lookup, reads, absent removal, silent discard
        send_request(REQ_LOOKUP, 16'sd5, 4'd0);
        send_request(REQ_READ, 16'sd0, 4'd0);
        send_request(REQ_READ, 16'sd0, 4'd15);
        send_request(REQ_REMOVE, 16'sd5, 4'd0);
        send_request(REQ_DISCARD, 16'sd5, 4'd0);
        // Values outside a byte never become members
        send_request(REQ_INSERT, 16'sh8000, 4'd0);
        send_request(REQ_INSERT, 16'sh7FFF, 4'd15);
        send_request(REQ_INSERT, 16'sd256, 4'd0);
        send_request(REQ_INSERT, -16'sd1, 4'd0);
        send_request(REQ_LOOKUP, -16'sd1, 4'd0);
        send_request(REQ_REMOVE, 16'sd300, 4'd0);
        send_request(REQ_DISCARD, -16'sd5, 4'd0);
        // Byte extremes and a duplicate
        send_request(REQ_INSERT, 16'sd0, 4'd0);
        send_request(REQ_INSERT, 16'sd255, 4'd0);
        send_request(REQ_INSERT, 16'sd0, 4'd0);
        send_request(REQ_INSERT, 16'sd128, 4'd0);
        send_request(REQ_READ, 16'sd0, 4'd0);
        send_request(REQ_READ, 16'sd0, 4'd1);
        send_request(REQ_READ, 16'sd0, 4'd2);
        send_request(REQ_READ, 16'sd0, 4'd3);
        // Unassigned codes change nothing
        send_request(REQ_SPARE, 16'sd255, 4'd1);
        send_request(REQ_SPARE + 3'd1, 16'sd255, 4'd0);
        send_request(REQ_SPARE + 3'd2, 16'sd255, 4'd2);
        // Remove the head and check the shift
        send_request(REQ_REMOVE, 16'sd0, 4'd0);
        send_request(REQ_READ, 16'sd0, 4'd0);
        drain();

        // Limit at the current count: full, but duplicate and range win
        write_limit(5'd2);
        send_request(REQ_INSERT, 16'sd77, 4'd0);
        send_request(REQ_INSERT, 16'sd255, 4'd0);
        send_request(REQ_INSERT, -16'sd2, 4'd0);
        drain();

        // Zero limit: every insert reports full
        write_limit(5'd0);
        send_request(REQ_INSERT, 16'sd9, 4'd0);
        drain();

        // Random phases, each under its own limit
        phase_limits = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd7, 5'd16,
                         5'd2, 5'd17, 5'd12, 5'd16, 5'd3, 5'd31};
        phase_limits[4] = 5'($urandom_range(0, 31));
        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            write_limit(phase_limits[p]);
            calm = (p == 5);
            pool_size = $urandom_range(4, 24);
            value_pool.delete();
            for (int unsigned i = 0; i < pool_size; i++)
                value_pool.push_back(8'($urandom_range(0, 255)));
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end
        calm = 1'b0;

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
